// ===== hdl/ssnf_pkg.sv =====
// Shared types, sizes and codes for the seven-segment number frame generator.
// Used by every module of the block and by its checker. No dependencies.
package ssnf_pkg;

  // Sizes of the display chain
  localparam int CHIP_COUNT   = 4;
  localparam int DIGIT_FRAMES = 9;
  localparam int CHIP_W       = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
  localparam int IDX_W        = (DIGIT_FRAMES > 1) ? $clog2(DIGIT_FRAMES) : 1;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 8;
  localparam int NUM_W        = 32;

  // Divide-by-ten reciprocal: q = (n * RECIP) >> RECIP_SHIFT, exact for 32 bits
  localparam logic [NUM_W-1:0] RECIP       = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  // Chip register addresses written by an init item
  localparam logic [ADDR_W-1:0] ADDR_INTENSITY  = 4'hA;
  localparam logic [ADDR_W-1:0] ADDR_SCAN_LIMIT = 4'hB;
  localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN   = 4'hC;

  // Operation codes
  localparam logic FUNC_INIT    = 1'b0;
  localparam logic FUNC_DISPLAY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_INTENSITY  = 2'd0;
  localparam logic [1:0] REG_SCAN_LIMIT = 2'd1;
  localparam logic [1:0] REG_RUN_MODE   = 2'd2;

  typedef struct packed {
    logic [3:0] intensity;
    logic [2:0] scan_limit;
    logic       run_mode;
  } cfg_t;

  // One item after digit extraction, handed to the frame serializer
  typedef struct packed {
    logic                             func;
    logic [1:0]                       chip;
    logic [DIGIT_FRAMES-1:0][3:0]     digits;
  } item_t;

  // Segment pattern of one decimal digit
  function automatic logic [DATA_W-1:0] seg_of(input logic [3:0] digit);
    logic [DATA_W-1:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h27;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/ssnf_digit_pipe.sv =====
// Digit extraction pipeline: one divide-by-ten stage per decimal digit.
// Depends on ssnf_pkg. All stages advance together on advance_i.
module ssnf_digit_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     in_valid_i,
  input  logic                     func_i,
  input  logic [1:0]               chip_i,
  input  logic [ssnf_pkg::NUM_W-1:0] number_i,
  output logic                     out_valid_o,
  output ssnf_pkg::item_t          out_item_o
);
  import ssnf_pkg::*;

  localparam int N = DIGIT_FRAMES;

  typedef struct packed {
    item_t            item;
    logic [NUM_W-1:0] num;
  } stage_t;

  logic   [N:0] valid_q;
  stage_t       stage_q [N+1];
  stage_t       stage_d [N+1];

  // Stage 0 takes the incoming beat
  always_comb begin
    stage_d[0].item.func   = func_i;
    stage_d[0].item.chip   = chip_i;
    stage_d[0].item.digits = '0;
    stage_d[0].num         = number_i;
  end

  // Each stage peels off the lowest digit of what is left
  for (genvar s = 0; s < N; s++) begin : g_div
    logic [2*NUM_W-1:0] prod;
    logic [NUM_W-1:0]   quot;
    logic [3:0]         q10;
    logic [3:0]         rem;

    always_comb begin
      prod = {{NUM_W{1'b0}}, stage_q[s].num} * {{NUM_W{1'b0}}, RECIP};
      quot = NUM_W'(prod >> RECIP_SHIFT);
      // low nibble of quot*10 is enough, the remainder stays below ten
      q10  = {quot[0], 3'b000} + {quot[2:0], 1'b0};
      rem  = stage_q[s].num[3:0] - q10;
      stage_d[s+1]                   = stage_q[s];
      stage_d[s+1].num               = quot;
      stage_d[s+1].item.digits[s]    = rem;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance_i) begin
      valid_q <= {valid_q[N-1:0], in_valid_i};
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int s = 0; s <= N; s++) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign out_valid_o = valid_q[N];
  assign out_item_o  = stage_q[N].item;

endmodule

// ===== hdl/ssnf_frame_ser.sv =====
// Frame serializer: turns one extracted item into its burst of register frames.
// Depends on ssnf_pkg. Emits one frame per cycle through an output register.
module ssnf_frame_ser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssnf_pkg::cfg_t              cfg_i,
  input  logic                        load_i,
  input  ssnf_pkg::item_t             item_i,
  output logic                        ready_o,
  output logic                        frame_valid_o,
  output logic [1:0]                  target_chip_o,
  output logic [ssnf_pkg::ADDR_W-1:0] reg_address_o,
  output logic [ssnf_pkg::DATA_W-1:0] reg_data_o,
  output logic                        last_o
);
  import ssnf_pkg::*;

  typedef enum logic [1:0] {
    SUB_INT,
    SUB_SCAN,
    SUB_SHUT
  } init_sub_e;

  logic              active_q;
  init_sub_e         sub_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CHIP_W-1:0] ichip_q;
  item_t             item_q;

  logic              frame_valid_q;
  logic [1:0]        chip_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic              last_q;

  logic [1:0]        chip_d;
  logic [ADDR_W-1:0] addr_d;
  logic [DATA_W-1:0] data_d;
  logic              final_d;
  logic [CHIP_W+1:0] ichip_ext;
  logic              take;

  // Frame for the current count
  always_comb begin
    ichip_ext = {2'b00, ichip_q};
    if (item_q.func == FUNC_DISPLAY) begin
      chip_d  = item_q.chip;
      addr_d  = ADDR_W'(DIGIT_FRAMES - 1) - ADDR_W'(idx_q);
      data_d  = seg_of(item_q.digits[idx_q]);
      final_d = (idx_q == IDX_W'(DIGIT_FRAMES - 1));
    end else begin
      chip_d  = ichip_ext[1:0];
      final_d = 1'b0;
      case (sub_q)
        SUB_INT: begin
          addr_d = ADDR_INTENSITY;
          data_d = {4'b0000, cfg_i.intensity};
        end
        SUB_SCAN: begin
          addr_d = ADDR_SCAN_LIMIT;
          data_d = {5'b00000, cfg_i.scan_limit};
        end
        SUB_SHUT: begin
          addr_d  = ADDR_SHUTDOWN;
          data_d  = {7'b0000000, cfg_i.run_mode};
          final_d = (ichip_q == CHIP_W'(CHIP_COUNT - 1));
        end
        default: begin
          addr_d = ADDR_INTENSITY;
          data_d = '0;
        end
      endcase
    end
  end

  // A new item may load while the last frame of the current one goes out
  assign ready_o = !active_q || final_d;
  assign take    = load_i && ready_o;

  // Counters and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      sub_q         <= SUB_INT;
      idx_q         <= '0;
      ichip_q       <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      frame_valid_q <= active_q;
      if (take) begin
        active_q <= 1'b1;
        sub_q    <= SUB_INT;
        idx_q    <= '0;
        ichip_q  <= '0;
      end else if (active_q && final_d) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        idx_q <= idx_q + IDX_W'(1);
        case (sub_q)
          SUB_INT:  sub_q <= SUB_SCAN;
          SUB_SCAN: sub_q <= SUB_SHUT;
          SUB_SHUT: begin
            sub_q   <= SUB_INT;
            ichip_q <= ichip_q + CHIP_W'(1);
          end
          default:  sub_q <= SUB_INT;
        endcase
      end
    end
  end

  // Item and frame payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
    chip_q <= chip_d;
    addr_q <= addr_d;
    data_q <= data_d;
    last_q <= final_d;
  end

  assign frame_valid_o = frame_valid_q;
  assign target_chip_o = chip_q;
  assign reg_address_o = addr_q;
  assign reg_data_o    = data_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/seven_segment_number_frame_generator_top.sv =====
// Top level: configuration registers, digit pipeline and frame serializer.
// Depends on ssnf_pkg, ssnf_digit_pipe and ssnf_frame_ser.
// Throughput: frames leave one per cycle, so an item occupies the output for 9
// frames (display) or 3*CHIP_COUNT = 12 frames (init); the serializer sets this.
// Up to DIGIT_FRAMES+1 items wait in the pipeline; busy is high while its last
// stage holds a beat the serializer cannot take yet, and the whole pipe holds.
// Reset (rst_ni low, async) empties the pipeline and loads the register defaults.
module seven_segment_number_frame_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [1:0]  chip_i,
  input  logic [31:0] number_i,
  // result channel
  output logic        result_valid_o,
  output logic [1:0]  target_chip_o,
  output logic [3:0]  reg_address_o,
  output logic [7:0]  reg_data_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssnf_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;
  logic       accept;
  logic       advance;
  logic       pipe_valid;
  item_t      pipe_item;
  logic       ser_ready;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.intensity  <= 4'd3;
      cfg_q.scan_limit <= 3'd7;
      cfg_q.run_mode   <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INTENSITY:  cfg_q.intensity  <= pwdata[3:0];
        REG_SCAN_LIMIT: cfg_q.scan_limit <= pwdata[2:0];
        REG_RUN_MODE:   cfg_q.run_mode   <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INTENSITY:  prdata = {28'd0, cfg_q.intensity};
      REG_SCAN_LIMIT: prdata = {29'd0, cfg_q.scan_limit};
      REG_RUN_MODE:   prdata = {31'd0, cfg_q.run_mode};
      default:        prdata = '0;
    endcase
  end

  // Pipeline moves unless its last stage waits on the serializer
  assign advance = !pipe_valid || ser_ready;
  assign busy    = !advance;
  assign accept  = start && !busy;

  ssnf_digit_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (accept),
    .func_i      (func_i),
    .chip_i      (chip_i),
    .number_i    (number_i),
    .out_valid_o (pipe_valid),
    .out_item_o  (pipe_item)
  );

  ssnf_frame_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .load_i        (pipe_valid),
    .item_i        (pipe_item),
    .ready_o       (ser_ready),
    .frame_valid_o (result_valid_o),
    .target_chip_o (target_chip_o),
    .reg_address_o (reg_address_o),
    .reg_data_o    (reg_data_o),
    .last_o        (last_o)
  );

endmodule

// ===== hdl/ssnf_checker.sv =====
// Port-level checker for the frame generator, bound to the top level.
// Depends on ssnf_pkg for the chip register addresses.
module ssnf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [1:0]  target_chip_o,
  input logic [3:0]  reg_address_o,
  input logic        last_o
);
  import ssnf_pkg::*;

  // A burst never has a gap before its final beat
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside a frame burst");

  // Address zero is only ever the closing digit frame
  a_addr_zero_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && reg_address_o == 4'd0 |-> last_o)
    else $error("address zero frame not marked last");

  // Digit frames step down one address on the same chip
  a_digit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o && reg_address_o < ADDR_INTENSITY |=>
      reg_address_o == $past(reg_address_o) - 4'd1 &&
      target_chip_o == $past(target_chip_o))
    else $error("digit frame sequence broken");

  // After the shutdown frame of one chip the next chip starts at intensity
  a_init_next_chip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o && reg_address_o == ADDR_SHUTDOWN |=>
      reg_address_o == ADDR_INTENSITY &&
      target_chip_o == $past(target_chip_o) + 2'd1)
    else $error("init sequence did not move to the next chip");

endmodule

bind seven_segment_number_frame_generator_top ssnf_checker u_ssnf_checker (.*);

// ===== tb/seven_segment_number_frame_generator_top_tb.sv =====
// Self-checking testbench for seven_segment_number_frame_generator_top.
// Predicts every register frame from the command beats and the register settings.
// Depends on ssnf_pkg and the top level only.
`timescale 1ns / 100ps

module seven_segment_number_frame_generator_top_tb;
  import ssnf_pkg::*;

  localparam int        CLK_PERIOD   = 20;
  localparam int        CYCLE_LIMIT  = 200000;
  localparam int        QUIET_CYCLES = 40;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic        func;
    logic [1:0]  chip;
    logic [31:0] number;
  } cmd_t;

  typedef struct packed {
    logic [1:0] chip;
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } frame_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        start    = 1'b0;
  logic        func_i   = 1'b0;
  logic [1:0]  chip_i   = '0;
  logic [31:0] number_i = '0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic        busy;
  logic        result_valid_o;
  logic [1:0]  target_chip_o;
  logic [3:0]  reg_address_o;
  logic [7:0]  reg_data_o;
  logic        last_o;
  logic [31:0] prdata;
  logic        pready;

  // Segment patterns for digits 0..9
  logic [7:0] seg_pattern [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                   8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F};

  cmd_t   cmd_pending_q [$];
  frame_t frame_due_q [$];
  cfg_t   chain_cfg;
  int     error_count = 0;
  int     cycle_count = 0;
  int     burst_left  = 0;
  int     gap_left    = 0;

  seven_segment_number_frame_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .chip_i         (chip_i),
    .number_i       (number_i),
    .result_valid_o (result_valid_o),
    .target_chip_o  (target_chip_o),
    .reg_address_o  (reg_address_o),
    .reg_data_o     (reg_data_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] MISMATCH: %s", cycle_count, msg);
    error_count++;
  endtask

  // Frames caused by one accepted command beat
  task automatic predict_frames(input cmd_t cmd);
    frame_t      fr;
    logic [31:0] rest;
    if (cmd.func == FUNC_INIT) begin
      for (int c = 0; c < CHIP_COUNT; c++) begin
        fr.chip = c[1:0];
        fr.last = 1'b0;
        fr.addr = ADDR_INTENSITY;
        fr.data = {4'b0, chain_cfg.intensity};
        frame_due_q.push_back(fr);
        fr.addr = ADDR_SCAN_LIMIT;
        fr.data = {5'b0, chain_cfg.scan_limit};
        frame_due_q.push_back(fr);
        fr.addr = ADDR_SHUTDOWN;
        fr.data = {7'b0, chain_cfg.run_mode};
        fr.last = (c == CHIP_COUNT - 1);
        frame_due_q.push_back(fr);
      end
    end else begin
      rest = cmd.number;
      for (int a = DIGIT_FRAMES - 1; a >= 0; a--) begin
        fr.chip = cmd.chip;
        fr.addr = a[3:0];
        fr.data = seg_pattern[4'(rest % 10)];
        fr.last = (a == 0);
        frame_due_q.push_back(fr);
        rest = rest / 10;
      end
    end
  endtask

  // Command driver: bursts of beats separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t cmd;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_frames('{func: func_i, chip: chip_i, number: number_i});
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_pending_q.size() > 0) begin
          cmd = cmd_pending_q.pop_front();
          func_i   <= cmd.func;
          chip_i   <= cmd.chip;
          number_i <= cmd.number;
          start    <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: every strobed frame must match the oldest prediction
  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && result_valid_o) begin
      if (frame_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected frame chip=%0d addr=%0d data=%02h last=%0b",
                                  target_chip_o, reg_address_o, reg_data_o, last_o));
      end else begin
        want = frame_due_q.pop_front();
        if (target_chip_o !== want.chip)
          report_mismatch($sformatf("target_chip %0d, want %0d", target_chip_o, want.chip));
        if (reg_address_o !== want.addr)
          report_mismatch($sformatf("reg_address %0d, want %0d", reg_address_o, want.addr));
        if (reg_data_o !== want.data)
          report_mismatch($sformatf("reg_data %02h, want %02h (addr %0d)",
                                    reg_data_o, want.data, want.addr));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("seven_segment_number_frame_generator_top_tb: done, errors");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want_rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INTENSITY:  chain_cfg.intensity  = value[3:0];
      REG_SCAN_LIMIT: chain_cfg.scan_limit = value[2:0];
      REG_RUN_MODE:   chain_cfg.run_mode   = value[0];
      default: ;
    endcase
    // Read back through the same address
    @(negedge clk_i);
    case (idx)
      REG_INTENSITY:  want_rd = {28'd0, chain_cfg.intensity};
      REG_SCAN_LIMIT: want_rd = {29'd0, chain_cfg.scan_limit};
      REG_RUN_MODE:   want_rd = {31'd0, chain_cfg.run_mode};
      default:        want_rd = '0;
    endcase
    if (prdata !== want_rd || pready !== 1'b1)
      report_mismatch($sformatf("readback reg %0d: prdata %08h, want %08h, pready %0b",
                                idx, prdata, want_rd, pready));
  endtask

  // Wait until every command is taken and every frame has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_pending_q.size() != 0 || start || frame_due_q.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_cmd(input logic f, input logic [1:0] c, input logic [31:0] n);
    cmd_pending_q.push_back('{func: f, chip: c, number: n});
  endtask

  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 4))
      0:       pick_number = $urandom;
      1:       pick_number = $urandom_range(0, 99);
      2:       pick_number = $urandom_range(0, 999999999);
      3:       pick_number = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: pick_number = $urandom_range(999990000, 1000010000);
    endcase
  endfunction

  // One init first so the new settings show up, then random commands
  task automatic queue_random(input int count);
    queue_cmd(FUNC_INIT, 2'($urandom), $urandom);
    for (int i = 1; i < count; i++) begin
      queue_cmd(($urandom_range(0, 4) == 0) ? FUNC_INIT : FUNC_DISPLAY,
                2'($urandom_range(0, 3)), pick_number());
    end
  endtask

  initial begin
    chain_cfg.intensity  = 4'd3;
    chain_cfg.scan_limit = 3'd7;
    chain_cfg.run_mode   = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults, digit extremes, dropped top digit, leading zeros
    queue_cmd(FUNC_INIT, 2'd2, 32'hDEAD_BEEF);
    queue_cmd(FUNC_DISPLAY, 2'd0, 32'd0);
    queue_cmd(FUNC_DISPLAY, 2'd1, 32'hFFFF_FFFF);
    queue_cmd(FUNC_DISPLAY, 2'd2, 32'd1234567890);
    queue_cmd(FUNC_DISPLAY, 2'd3, 32'd987654321);
    queue_cmd(FUNC_DISPLAY, 2'd0, 32'd999999999);
    queue_cmd(FUNC_DISPLAY, 2'd1, 32'd1000000000);
    queue_cmd(FUNC_DISPLAY, 2'd2, 32'd100000000);
    queue_cmd(FUNC_DISPLAY, 2'd3, 32'd7);
    queue_cmd(FUNC_DISPLAY, 2'd0, 32'd10);
    queue_cmd(FUNC_DISPLAY, 2'd3, 32'h8000_0000);
    queue_cmd(FUNC_INIT, 2'd0, 32'd0);
    wait_drained();

    // Lowest settings
    reg_write(REG_INTENSITY, 32'd0);
    reg_write(REG_SCAN_LIMIT, 32'd0);
    reg_write(REG_RUN_MODE, 32'd0);
    queue_random(60);
    wait_drained();

    // Highest settings, written with high bits set; unmapped index is ignored
    reg_write(REG_INTENSITY, 32'hFFFF_FFFF);
    reg_write(REG_SCAN_LIMIT, 32'hFFFF_FFFF);
    reg_write(REG_RUN_MODE, 32'hFFFF_FFFF);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    queue_random(60);
    wait_drained();

    // Random settings
    for (int p = 0; p < 4; p++) begin
      reg_write(REG_INTENSITY, $urandom);
      reg_write(REG_SCAN_LIMIT, $urandom);
      reg_write(REG_RUN_MODE, $urandom);
      reg_write(REG_UNUSED, $urandom);
      queue_random(48);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("seven_segment_number_frame_generator_top_tb: done, clean");
    end else begin
      $display("seven_segment_number_frame_generator_top_tb: done, errors");
    end
    $finish;
  end

endmodule
